/* hdl/bgtr_pkg.sv */
package bgtr_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int SCALE_BITS_DEF = 6;

  localparam int GLYPH_ROWS    = 5;
  localparam int GLYPH_COLS    = 3;
  localparam int CELLS         = GLYPH_ROWS * GLYPH_COLS;
  localparam int ADVANCE_CELLS = 4;

  localparam int CHAR_BITS   = 8;
  localparam int CURSOR_BITS = 16;
  localparam int PIX_BITS    = 12;
  localparam int COLOR_BITS  = 24;
  localparam int SCREEN_BITS = 13;

  localparam int SCREEN_MAX = 4096;
  localparam int CURSOR_MAX = 32767;
  localparam int CURSOR_MIN = -32768;

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] glyph_rows_t;

  // one classified character: visible cells, the coordinates of each column and row, and its color
  typedef struct packed {
    logic [CELLS-1:0]                     mask;
    logic [GLYPH_COLS-1:0][PIX_BITS-1:0]  col_x;
    logic [GLYPH_ROWS-1:0][PIX_BITS-1:0]  row_y;
    logic [COLOR_BITS-1:0]                color;
  } entry_t;

  // each octal digit is one glyph row, top row first, msb is the left column
  function automatic glyph_rows_t glyph_rows(input logic [CHAR_BITS-1:0] code);
    glyph_rows_t g;
    unique case (code)
      8'h41:   g = 15'o25755;
      8'h42:   g = 15'o65656;
      8'h43:   g = 15'o34443;
      8'h44:   g = 15'o65556;
      8'h45:   g = 15'o74647;
      8'h46:   g = 15'o74644;
      8'h47:   g = 15'o34553;
      8'h48:   g = 15'o55755;
      8'h49:   g = 15'o72227;
      8'h4A:   g = 15'o11152;
      8'h4B:   g = 15'o55655;
      8'h4C:   g = 15'o44447;
      8'h4D:   g = 15'o57755;
      8'h4E:   g = 15'o57775;
      8'h4F:   g = 15'o25552;
      8'h50:   g = 15'o65644;
      8'h51:   g = 15'o25573;
      8'h52:   g = 15'o65655;
      8'h53:   g = 15'o34216;
      8'h54:   g = 15'o72222;
      8'h55:   g = 15'o55557;
      8'h56:   g = 15'o55552;
      8'h57:   g = 15'o55775;
      8'h58:   g = 15'o55255;
      8'h59:   g = 15'o55222;
      8'h5A:   g = 15'o71247;
      8'h30:   g = 15'o75557;
      8'h31:   g = 15'o26227;
      8'h32:   g = 15'o61247;
      8'h33:   g = 15'o61216;
      8'h34:   g = 15'o55711;
      8'h35:   g = 15'o74616;
      8'h36:   g = 15'o34757;
      8'h37:   g = 15'o71222;
      8'h38:   g = 15'o75757;
      8'h39:   g = 15'o75716;
      8'h2E:   g = 15'o00002;
      8'h2F:   g = 15'o11244;
      8'h2D:   g = 15'o00700;
      8'h3A:   g = 15'o02020;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* hdl/bgtr_front.sv */
module bgtr_front #(
  parameter int COORD_BITS = bgtr_pkg::COORD_BITS_DEF,
  parameter int SCALE_BITS = bgtr_pkg::SCALE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bgtr_pkg::CHAR_BITS-1:0]        char_code_i,
  input  logic                                  first_of_string_i,
  input  logic signed [COORD_BITS-1:0]          origin_x_i,
  input  logic signed [COORD_BITS-1:0]          origin_y_i,
  input  logic [SCALE_BITS-1:0]                 scale_i,
  input  logic [bgtr_pkg::COLOR_BITS-1:0]       color_rgb_i,
  input  logic [bgtr_pkg::SCREEN_BITS-1:0]      width_i,
  input  logic [bgtr_pkg::SCREEN_BITS-1:0]      height_i,
  input  logic                                  q_full_i,
  output logic                                  push_o,
  output bgtr_pkg::entry_t                      push_entry_o,
  output logic [SCALE_BITS-1:0]                 push_size_o
);

  localparam int PW    = bgtr_pkg::CURSOR_BITS + SCALE_BITS + 4;
  localparam int ROWS  = bgtr_pkg::GLYPH_ROWS;
  localparam int COLS  = bgtr_pkg::GLYPH_COLS;
  localparam int CB    = bgtr_pkg::CURSOR_BITS;
  localparam int SB    = bgtr_pkg::SCREEN_BITS;
  localparam int PB    = bgtr_pkg::PIX_BITS;

  logic signed [CB-1:0] cursor_q, cursor_d, cur_eff, cur_sat;
  logic signed [PW-1:0] cur_ext, oy_ext, scale_ext, w_ms, h_ms, adv_sum;
  logic signed [PW-1:0] px [COLS];
  logic signed [PW-1:0] py [ROWS];
  logic signed [PW-1:0] ry [ROWS];
  logic [COLS-1:0]      col_ok;
  logic [ROWS-1:0]      row_ok;
  logic [SB-1:0]        w_lim, h_lim;
  logic                 scale_nz, accept;
  bgtr_pkg::glyph_rows_t glyph;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign scale_nz   = (scale_i != '0);

  assign w_lim = (width_i > SB'(bgtr_pkg::SCREEN_MAX)) ? SB'(bgtr_pkg::SCREEN_MAX) : width_i;
  assign h_lim = (height_i > SB'(bgtr_pkg::SCREEN_MAX)) ? SB'(bgtr_pkg::SCREEN_MAX) : height_i;

  assign cur_eff   = first_of_string_i ? CB'(origin_x_i) : cursor_q;
  assign cur_ext   = PW'(cur_eff);
  assign oy_ext    = PW'(origin_y_i);
  assign scale_ext = signed'(PW'(scale_i));
  assign w_ms      = signed'(PW'(w_lim)) - scale_ext;
  assign h_ms      = signed'(PW'(h_lim)) - scale_ext;
  assign glyph     = bgtr_pkg::glyph_rows(char_code_i);

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      px[c]     = cur_ext + PW'(c) * scale_ext;
      col_ok[c] = !px[c][PW-1] && (px[c] <= w_ms);
    end
    for (int r = 0; r < ROWS; r++) begin
      py[r]     = oy_ext + PW'(r) * scale_ext;
      ry[r]     = h_ms - py[r];
      row_ok[r] = !py[r][PW-1] && !ry[r][PW-1];
    end
  end

  always_comb begin
    push_entry_o.color = color_rgb_i;
    for (int c = 0; c < COLS; c++) begin
      push_entry_o.col_x[c] = px[c][PB-1:0];
    end
    for (int r = 0; r < ROWS; r++) begin
      push_entry_o.row_y[r] = ry[r][PB-1:0];
      for (int c = 0; c < COLS; c++) begin
        push_entry_o.mask[r*COLS+c] = glyph[r][COLS-1-c] && col_ok[c] && row_ok[r] && scale_nz;
      end
    end
  end

  assign push_size_o = scale_i;
  assign push_o      = accept && (push_entry_o.mask != '0);

  // pen advance with saturation at the cursor range
  always_comb begin
    adv_sum = cur_ext + PW'(bgtr_pkg::ADVANCE_CELLS) * scale_ext;
    if (adv_sum > PW'(bgtr_pkg::CURSOR_MAX)) begin
      cur_sat = CB'(bgtr_pkg::CURSOR_MAX);
    end else if (adv_sum < PW'(bgtr_pkg::CURSOR_MIN)) begin
      cur_sat = CB'(bgtr_pkg::CURSOR_MIN);
    end else begin
      cur_sat = adv_sum[CB-1:0];
    end
    cursor_d = cursor_q;
    if (accept) begin
      cursor_d = scale_nz ? cur_sat : cur_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

endmodule

/* hdl/bgtr_queue.sv */
module bgtr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bgtr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output logic [WIDTH-1:0] head_data_o
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    store_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o       = (count_q == CNT_BITS'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = store_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/bgtr_back.sv */
module bgtr_back #(
  parameter int SCALE_BITS = bgtr_pkg::SCALE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  bgtr_pkg::entry_t                  head_entry_i,
  input  logic [SCALE_BITS-1:0]             head_size_i,
  output logic                              pop_o,
  output logic                              rect_valid_o,
  input  logic                              rect_ready_i,
  output logic [bgtr_pkg::PIX_BITS-1:0]     rect_x_o,
  output logic [bgtr_pkg::PIX_BITS-1:0]     rect_y_o,
  output logic [SCALE_BITS-1:0]             rect_size_o,
  output logic [bgtr_pkg::COLOR_BITS-1:0]   rect_color_o,
  output logic                              last_of_char_o
);

  localparam int ROWS   = bgtr_pkg::GLYPH_ROWS;
  localparam int COLS   = bgtr_pkg::GLYPH_COLS;
  localparam int CELLS  = bgtr_pkg::CELLS;
  localparam int R_BITS = $clog2(ROWS);
  localparam int C_BITS = $clog2(COLS);
  localparam int N_BITS = $clog2(CELLS);

  logic                   busy_q, busy_d;
  logic                   valid_q, valid_d;
  bgtr_pkg::entry_t       work_q;
  logic [CELLS-1:0]       mask_d, rem;
  logic [SCALE_BITS-1:0]  size_q;
  logic [R_BITS-1:0]      sel_r;
  logic [C_BITS-1:0]      sel_c;
  logic [N_BITS-1:0]      sel_n;
  logic                   adv, emit, last, load;

  // lowest set cell in row-major order
  always_comb begin
    sel_r = '0;
    sel_c = '0;
    sel_n = '0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      for (int c = COLS - 1; c >= 0; c--) begin
        if (work_q.mask[r*COLS+c]) begin
          sel_r = R_BITS'(r);
          sel_c = C_BITS'(c);
          sel_n = N_BITS'(r * COLS + c);
        end
      end
    end
  end

  assign rem   = work_q.mask & ~(CELLS'(1) << sel_n);
  assign last  = (rem == '0);
  assign adv   = !valid_q || rect_ready_i;
  assign emit  = busy_q && adv;
  assign load  = head_valid_i && (!busy_q || (emit && last));
  assign pop_o = load;

  always_comb begin
    busy_d  = busy_q;
    valid_d = valid_q;
    mask_d  = work_q.mask;
    if (emit) begin
      valid_d = 1'b1;
      mask_d  = rem;
      busy_d  = !last;
    end else if (rect_ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      busy_d = 1'b1;
      mask_d = head_entry_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q.mask <= mask_d;
    if (load) begin
      work_q.col_x <= head_entry_i.col_x;
      work_q.row_y <= head_entry_i.row_y;
      work_q.color <= head_entry_i.color;
      size_q       <= head_size_i;
    end
    if (emit) begin
      rect_x_o       <= work_q.col_x[sel_c];
      rect_y_o       <= work_q.row_y[sel_r];
      rect_size_o    <= size_q;
      rect_color_o   <= work_q.color;
      last_of_char_o <= last;
    end
  end

  assign rect_valid_o = valid_q;

endmodule

/* hdl/bitmap_glyph_text_rasterizer.sv */
// Text rasterizer with a built-in 3x5 font. Each character transfer on the input channel is
// classified in the cycle it is taken (glyph lookup, cursor update, clipping of every glyph
// column and row against the screen) and placed in a two-entry queue; the character is accepted
// whenever the queue has room. The drawing side then sends one square per cycle on the result
// channel while rect_ready_i is high, so a character yields one square per visible lit cell,
// 0 to 13; blank, unknown, zero-scale and fully clipped characters yield no squares. Squares
// pass from the queue through the working register to the output register. Screen width sits
// at byte address 0x0 and height at 0x4 (13 bits each, reset 640 and 480); change them only
// while no character is in flight.
module bitmap_glyph_text_rasterizer #(
  parameter int COORD_BITS = bgtr_pkg::COORD_BITS_DEF,
  parameter int SCALE_BITS = bgtr_pkg::SCALE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bgtr_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [bgtr_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [bgtr_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [bgtr_pkg::CHAR_BITS-1:0]        char_code_i,
  input  logic                                  first_of_string_i,
  input  logic signed [COORD_BITS-1:0]          origin_x_i,
  input  logic signed [COORD_BITS-1:0]          origin_y_i,
  input  logic [SCALE_BITS-1:0]                 scale_i,
  input  logic [bgtr_pkg::COLOR_BITS-1:0]       color_rgb_i,
  output logic                                  rect_valid_o,
  input  logic                                  rect_ready_i,
  output logic [bgtr_pkg::PIX_BITS-1:0]         rect_x_o,
  output logic [bgtr_pkg::PIX_BITS-1:0]         rect_y_o,
  output logic [SCALE_BITS-1:0]                 rect_size_o,
  output logic [bgtr_pkg::COLOR_BITS-1:0]       rect_color_o,
  output logic                                  last_of_char_o
);

  localparam int SB     = bgtr_pkg::SCREEN_BITS;
  localparam int EW     = $bits(bgtr_pkg::entry_t);
  localparam int QW     = EW + SCALE_BITS;
  localparam int CHK    = bgtr_pkg::PIX_BITS + 2;

  logic [SB-1:0]          width_q, width_d, height_q, height_d;
  bgtr_pkg::reg_idx_e     reg_idx;
  logic                   cfg_wr;

  logic                   push, q_full, head_valid, pop;
  bgtr_pkg::entry_t       push_entry;
  logic [SCALE_BITS-1:0]  push_size;
  logic [QW-1:0]          head_data;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = bgtr_pkg::reg_idx_e'(paddr[bgtr_pkg::APB_ADDR_BITS-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        bgtr_pkg::REG_WIDTH:  width_d  = pwdata[SB-1:0];
        bgtr_pkg::REG_HEIGHT: height_d = pwdata[SB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bgtr_pkg::REG_WIDTH:  prdata = bgtr_pkg::APB_DATA_BITS'(width_q);
      bgtr_pkg::REG_HEIGHT: prdata = bgtr_pkg::APB_DATA_BITS'(height_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bgtr_pkg::WIDTH_RESET;
      height_q <= bgtr_pkg::HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  bgtr_front #(
    .COORD_BITS (COORD_BITS),
    .SCALE_BITS (SCALE_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .char_code_i       (char_code_i),
    .first_of_string_i (first_of_string_i),
    .origin_x_i        (origin_x_i),
    .origin_y_i        (origin_y_i),
    .scale_i           (scale_i),
    .color_rgb_i       (color_rgb_i),
    .width_i           (width_q),
    .height_i          (height_q),
    .q_full_i          (q_full),
    .push_o            (push),
    .push_entry_o      (push_entry),
    .push_size_o       (push_size)
  );

  bgtr_queue #(
    .WIDTH (QW),
    .DEPTH (bgtr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  ({push_entry, push_size}),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  bgtr_back #(
    .SCALE_BITS (SCALE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_entry_i   (bgtr_pkg::entry_t'(head_data[QW-1:SCALE_BITS])),
    .head_size_i    (head_data[SCALE_BITS-1:0]),
    .pop_o          (pop),
    .rect_valid_o   (rect_valid_o),
    .rect_ready_i   (rect_ready_i),
    .rect_x_o       (rect_x_o),
    .rect_y_o       (rect_y_o),
    .rect_size_o    (rect_size_o),
    .rect_color_o   (rect_color_o),
    .last_of_char_o (last_of_char_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("character pushed into a full queue");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> (rect_size_o != '0))
    else $error("square of zero size");

  a_x_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> ((CHK'(rect_x_o) + CHK'(rect_size_o)) <= CHK'(width_q)))
    else $error("square crosses the right edge");

  a_y_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid_o |-> ((CHK'(rect_y_o) + CHK'(rect_size_o)) <= CHK'(height_q)))
    else $error("square crosses the top edge");

endmodule

/* bench/bitmap_glyph_text_rasterizer_test.sv */
`timescale 1ns / 1ps

module bitmap_glyph_text_rasterizer_test;

  localparam int COORD_W        = bgtr_pkg::COORD_BITS_DEF;
  localparam int SCALE_W        = bgtr_pkg::SCALE_BITS_DEF;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_AFTER     = 40;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [bgtr_pkg::CHAR_BITS-1:0]  code;
    logic                            first;
    logic [COORD_W-1:0]              origin_x;
    logic [COORD_W-1:0]              origin_y;
    logic [SCALE_W-1:0]              scale;
    logic [bgtr_pkg::COLOR_BITS-1:0] color;
  } text_char_t;

  typedef struct packed {
    logic [bgtr_pkg::PIX_BITS-1:0]   x;
    logic [bgtr_pkg::PIX_BITS-1:0]   y;
    logic [SCALE_W-1:0]              side;
    logic [bgtr_pkg::COLOR_BITS-1:0] color;
    logic                            last;
  } square_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 psel;
  logic                                 penable;
  logic                                 pwrite;
  logic [bgtr_pkg::APB_ADDR_BITS-1:0]   paddr;
  logic [bgtr_pkg::APB_DATA_BITS-1:0]   pwdata;
  logic [bgtr_pkg::APB_DATA_BITS-1:0]   prdata;
  logic                                 pready;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic [bgtr_pkg::CHAR_BITS-1:0]       char_code_i;
  logic                                 first_of_string_i;
  logic signed [COORD_W-1:0]            origin_x_i;
  logic signed [COORD_W-1:0]            origin_y_i;
  logic [SCALE_W-1:0]                   scale_i;
  logic [bgtr_pkg::COLOR_BITS-1:0]      color_rgb_i;
  logic                                 rect_valid_o;
  logic                                 rect_ready_i;
  logic [bgtr_pkg::PIX_BITS-1:0]        rect_x_o;
  logic [bgtr_pkg::PIX_BITS-1:0]        rect_y_o;
  logic [SCALE_W-1:0]                   rect_size_o;
  logic [bgtr_pkg::COLOR_BITS-1:0]      rect_color_o;
  logic                                 last_of_char_o;

  text_char_t         text_queue[$];
  square_t            pending_squares[$];
  logic [bgtr_pkg::SCREEN_BITS-1:0] screen_w;
  logic [bgtr_pkg::SCREEN_BITS-1:0] screen_h;
  int                 pen_x;
  int                 chars_queued;
  int                 chars_taken;
  int                 squares_checked;
  int                 errors;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 hold_left;
  bit                 hold_done;
  int                 stall_cycles;
  logic               in_fire;

  bitmap_glyph_text_rasterizer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .first_of_string_i(first_of_string_i),
    .origin_x_i       (origin_x_i),
    .origin_y_i       (origin_y_i),
    .scale_i          (scale_i),
    .color_rgb_i      (color_rgb_i),
    .rect_valid_o     (rect_valid_o),
    .rect_ready_i     (rect_ready_i),
    .rect_x_o         (rect_x_o),
    .rect_y_o         (rect_y_o),
    .rect_size_o      (rect_size_o),
    .rect_color_o     (rect_color_o),
    .last_of_char_o   (last_of_char_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // top row first, msb of each row is the left column
  function automatic logic [bgtr_pkg::CELLS-1:0] font_bits(
      input logic [bgtr_pkg::CHAR_BITS-1:0] code);
    logic [bgtr_pkg::CELLS-1:0] bits;
    case (code)
      "A": bits = 15'b010_101_111_101_101;
      "B": bits = 15'b110_101_110_101_110;
      "C": bits = 15'b011_100_100_100_011;
      "D": bits = 15'b110_101_101_101_110;
      "E": bits = 15'b111_100_110_100_111;
      "F": bits = 15'b111_100_110_100_100;
      "G": bits = 15'b011_100_101_101_011;
      "H": bits = 15'b101_101_111_101_101;
      "I": bits = 15'b111_010_010_010_111;
      "J": bits = 15'b001_001_001_101_010;
      "K": bits = 15'b101_101_110_101_101;
      "L": bits = 15'b100_100_100_100_111;
      "M": bits = 15'b101_111_111_101_101;
      "N": bits = 15'b101_111_111_111_101;
      "O": bits = 15'b010_101_101_101_010;
      "P": bits = 15'b110_101_110_100_100;
      "Q": bits = 15'b010_101_101_111_011;
      "R": bits = 15'b110_101_110_101_101;
      "S": bits = 15'b011_100_010_001_110;
      "T": bits = 15'b111_010_010_010_010;
      "U": bits = 15'b101_101_101_101_111;
      "V": bits = 15'b101_101_101_101_010;
      "W": bits = 15'b101_101_111_111_101;
      "X": bits = 15'b101_101_010_101_101;
      "Y": bits = 15'b101_101_010_010_010;
      "Z": bits = 15'b111_001_010_100_111;
      "0": bits = 15'b111_101_101_101_111;
      "1": bits = 15'b010_110_010_010_111;
      "2": bits = 15'b110_001_010_100_111;
      "3": bits = 15'b110_001_010_001_110;
      "4": bits = 15'b101_101_111_001_001;
      "5": bits = 15'b111_100_110_001_110;
      "6": bits = 15'b011_100_111_101_111;
      "7": bits = 15'b111_001_010_010_010;
      "8": bits = 15'b111_101_111_101_111;
      "9": bits = 15'b111_101_111_001_110;
      ".": bits = 15'b000_000_000_000_010;
      "/": bits = 15'b001_001_010_100_100;
      "-": bits = 15'b000_000_111_000_000;
      ":": bits = 15'b000_010_000_010_000;
      default: bits = '0;
    endcase
    return bits;
  endfunction

  function automatic void rasterize_char(input text_char_t ch);
    logic [bgtr_pkg::CELLS-1:0] glyph;
    square_t sq;
    square_t held;
    bit have_held;
    int w, h, sc, oy, px, py, nxt;
    w = (screen_w > bgtr_pkg::SCREEN_MAX) ? bgtr_pkg::SCREEN_MAX : int'(screen_w);
    h = (screen_h > bgtr_pkg::SCREEN_MAX) ? bgtr_pkg::SCREEN_MAX : int'(screen_h);
    if (ch.first) pen_x = $signed(ch.origin_x);
    sc = int'(ch.scale);
    if (sc == 0) return;
    glyph = font_bits(ch.code);
    oy = $signed(ch.origin_y);
    have_held = 1'b0;
    for (int r = 0; r < bgtr_pkg::GLYPH_ROWS; r++) begin
      for (int c = 0; c < bgtr_pkg::GLYPH_COLS; c++) begin
        if (glyph[bgtr_pkg::CELLS-1-(r*bgtr_pkg::GLYPH_COLS+c)]) begin
          px = pen_x + c * sc;
          py = oy + r * sc;
          if (px >= 0 && py >= 0 && px + sc <= w && py + sc <= h) begin
            sq.x = bgtr_pkg::PIX_BITS'(px);
            sq.y = bgtr_pkg::PIX_BITS'(h - py - sc);
            sq.side = ch.scale;
            sq.color = ch.color;
            sq.last = 1'b0;
            if (have_held) pending_squares = {pending_squares, held};
            held = sq;
            have_held = 1'b1;
          end
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_squares = {pending_squares, held};
    end
    nxt = pen_x + bgtr_pkg::ADVANCE_CELLS * sc;
    if (nxt > bgtr_pkg::CURSOR_MAX) nxt = bgtr_pkg::CURSOR_MAX;
    if (nxt < bgtr_pkg::CURSOR_MIN) nxt = bgtr_pkg::CURSOR_MIN;
    pen_x = nxt;
  endfunction

  // input side: new item only once the previous one is taken
  always @(negedge clk_i) begin : feed_chars
    text_char_t ch;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        ch = text_queue.pop_front();
        in_valid_i <= 1'b1;
        char_code_i <= ch.code;
        first_of_string_i <= ch.first;
        origin_x_i <= ch.origin_x;
        origin_y_i <= ch.origin_y;
        scale_i <= ch.scale;
        color_rgb_i <= ch.color;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side backpressure, with one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && squares_checked >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rect_ready_i <= 1'b0;
      end else begin
        rect_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : watch_ports
    text_char_t taken;
    square_t want;
    in_fire <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        taken.code = char_code_i;
        taken.first = first_of_string_i;
        taken.origin_x = origin_x_i;
        taken.origin_y = origin_y_i;
        taken.scale = scale_i;
        taken.color = color_rgb_i;
        rasterize_char(taken);
        chars_taken++;
      end
      if (rect_valid_o && rect_ready_i) begin
        squares_checked++;
        if (pending_squares.size() == 0) begin
          $error("unexpected square transfer: x %0d y %0d", rect_x_o, rect_y_o);
          errors++;
        end else begin
          want = pending_squares.pop_front();
          if (rect_x_o !== want.x) begin
            $error("rect_x: expected %0d, got %0d", want.x, rect_x_o);
            errors++;
          end
          if (rect_y_o !== want.y) begin
            $error("rect_y: expected %0d, got %0d", want.y, rect_y_o);
            errors++;
          end
          if (rect_size_o !== want.side) begin
            $error("rect_size: expected %0d, got %0d", want.side, rect_size_o);
            errors++;
          end
          if (rect_color_o !== want.color) begin
            $error("rect_color: expected %06h, got %06h", want.color, rect_color_o);
            errors++;
          end
          if (last_of_char_o !== want.last) begin
            $error("last_of_char: expected %0d, got %0d", want.last, last_of_char_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (rect_valid_o && rect_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("bitmap_glyph_text_rasterizer regression: fail");
      $finish;
    end
  end

  // write, then read back in a back-to-back transfer
  task automatic set_screen_reg(input bgtr_pkg::reg_idx_e idx,
                                input logic [bgtr_pkg::SCREEN_BITS-1:0] value);
    logic [bgtr_pkg::APB_DATA_BITS-1:0] rd;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= bgtr_pkg::APB_DATA_BITS'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (idx == bgtr_pkg::REG_WIDTH) begin
      screen_w = value;
    end else begin
      screen_h = value;
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[bgtr_pkg::SCREEN_BITS-1:0] !== value) begin
      $error("prdata: expected %0d, got %0d", value, rd[bgtr_pkg::SCREEN_BITS-1:0]);
      errors++;
    end
  endtask

  task automatic add_char(input logic [bgtr_pkg::CHAR_BITS-1:0] code, input bit first,
                          input int ox, input int oy, input int sc,
                          input logic [bgtr_pkg::COLOR_BITS-1:0] color);
    text_char_t ch;
    ch.code = code;
    ch.first = first;
    ch.origin_x = COORD_W'(ox);
    ch.origin_y = COORD_W'(oy);
    ch.scale = SCALE_W'(sc);
    ch.color = color;
    text_queue = {text_queue, ch};
    chars_queued++;
  endtask

  function automatic logic [bgtr_pkg::CHAR_BITS-1:0] pick_code();
    int k;
    k = $urandom_range(99);
    if (k < 12) return bgtr_pkg::CHAR_BITS'($urandom_range(255));
    k = $urandom_range(39);
    if (k < 26) return bgtr_pkg::CHAR_BITS'("A" + k);
    if (k < 36) return bgtr_pkg::CHAR_BITS'("0" + k - 26);
    case (k)
      36: return ".";
      37: return "/";
      38: return "-";
      default: return ":";
    endcase
  endfunction

  function automatic int pick_scale();
    int k;
    k = $urandom_range(99);
    if (k < 5) return 0;
    if (k < 75) return $urandom_range(1, 4);
    if (k < 92) return $urandom_range(5, 16);
    return $urandom_range(17, 63);
  endfunction

  // mostly strings placed near the screen, some raw noise
  task automatic add_text(input int n_items);
    int made, len, k, w_eff, h_eff, ox, oy, sc;
    logic [bgtr_pkg::COLOR_BITS-1:0] ink;
    made = 0;
    w_eff = (screen_w > bgtr_pkg::SCREEN_MAX) ? bgtr_pkg::SCREEN_MAX : int'(screen_w);
    h_eff = (screen_h > bgtr_pkg::SCREEN_MAX) ? bgtr_pkg::SCREEN_MAX : int'(screen_h);
    while (made < n_items) begin
      if ($urandom_range(99) < 15) begin
        add_char(bgtr_pkg::CHAR_BITS'($urandom), 1'($urandom), int'($urandom),
                 int'($urandom), int'($urandom), bgtr_pkg::COLOR_BITS'($urandom));
        made++;
      end else begin
        len = $urandom_range(1, 8);
        ox = int'($urandom_range(0, w_eff + 40)) - 20;
        oy = int'($urandom_range(0, h_eff + 40)) - 20;
        if (ox > 4095) ox = 4095;
        if (oy > 4095) oy = 4095;
        sc = pick_scale();
        ink = bgtr_pkg::COLOR_BITS'($urandom);
        for (k = 0; k < len && made < n_items; k++) begin
          if ($urandom_range(9) == 0) sc = pick_scale();
          if ($urandom_range(9) == 0) ink = bgtr_pkg::COLOR_BITS'($urandom);
          add_char(pick_code(), k == 0, (k == 0) ? ox : int'($urandom), oy, sc, ink);
          made++;
        end
      end
    end
  endtask

  // one long string at full scale, runs the cursor into saturation
  task automatic add_long_line(input int n_items);
    int k, oy;
    oy = $urandom_range(0, 3700);
    for (k = 0; k < n_items; k++) begin
      add_char(pick_code(), k == 0, 0, oy, 63, bgtr_pkg::COLOR_BITS'($urandom));
    end
  endtask

  task automatic drain_text();
    while (chars_taken != chars_queued || pending_squares.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int k;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    char_code_i = '0;
    first_of_string_i = 1'b0;
    origin_x_i = '0;
    origin_y_i = '0;
    scale_i = '0;
    color_rgb_i = '0;
    rect_ready_i = 1'b0;
    in_fire = 1'b0;
    screen_w = bgtr_pkg::WIDTH_RESET;
    screen_h = bgtr_pkg::HEIGHT_RESET;
    pen_x = 0;
    chars_queued = 0;
    chars_taken = 0;
    squares_checked = 0;
    errors = 0;
    hold_left = 0;
    hold_done = 1'b0;
    stall_cycles = 0;
    send_idle_pct = 11;
    recv_idle_pct = 58;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    add_char("8", 1, 0, 0, 1, 24'h000000);
    add_char("N", 1, 10, 100, 63, 24'hFFFFFF);
    add_char("M", 0, 0, 100, 63, 24'h123456);
    add_char(8'h00, 1, 0, 0, 5, 24'hA5A5A5);
    add_char(8'hFF, 0, -4096, 0, 5, 24'h5A5A5A);
    add_char("A", 0, 4095, 0, 5, 24'h00FF00);
    add_char("W", 1, 100, 100, 0, 24'hFF0000);
    add_char("W", 0, 0, 100, 2, 24'h0000FF);
    add_char("a", 0, 0, 100, 3, 24'h808080);
    add_char("H", 1, -4096, 0, 1, 24'h010203);
    add_char("0", 1, -3, 10, 2, 24'h0F0F0F);
    add_char("8", 1, 50, -4, 2, 24'hF0F0F0);
    add_char("8", 1, 636, 0, 2, 24'h336699);
    add_char("8", 1, 0, 472, 2, 24'h996633);
    add_char("8", 1, 4095, 4095, 63, 24'hC0FFEE);
    add_char("8", 1, -4096, -4096, 63, 24'h7F7F7F);
    add_char(".", 1, 300, 300, 3, 24'h111111);
    add_char("/", 0, 0, 300, 3, 24'h222222);
    add_char("-", 0, 0, 300, 3, 24'h333333);
    add_char(":", 0, 0, 300, 3, 24'h444444);
    add_char("Q", 0, 0, 300, 63, 24'h555555);
    add_char("1", 1, 0, 0, 1, 24'h666666);
    add_text(50);
    drain_text();

    set_screen_reg(bgtr_pkg::REG_WIDTH, 13'd4096);
    set_screen_reg(bgtr_pkg::REG_HEIGHT, 13'd4096);
    add_long_line(140);
    add_text(50);
    drain_text();

    send_idle_pct = 58;
    recv_idle_pct = 11;
    set_screen_reg(bgtr_pkg::REG_WIDTH, 13'd1);
    set_screen_reg(bgtr_pkg::REG_HEIGHT, 13'd1);
    for (k = 0; k < 10; k++) begin
      add_char(pick_code(), 1, 0, 0, 1, bgtr_pkg::COLOR_BITS'($urandom));
    end
    drain_text();

    set_screen_reg(bgtr_pkg::REG_WIDTH, 13'd8191);
    set_screen_reg(bgtr_pkg::REG_HEIGHT, 13'd8191);
    add_text(50);
    drain_text();

    set_screen_reg(bgtr_pkg::REG_WIDTH, 13'd0);
    set_screen_reg(bgtr_pkg::REG_HEIGHT, 13'd0);
    add_text(10);
    drain_text();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_screen_reg(bgtr_pkg::REG_WIDTH, 13'd320);
    set_screen_reg(bgtr_pkg::REG_HEIGHT, 13'd200);
    add_text(40);
    drain_text();

    set_screen_reg(bgtr_pkg::REG_WIDTH, 13'd4095);
    set_screen_reg(bgtr_pkg::REG_HEIGHT, 13'd17);
    add_text(30);
    drain_text();

    set_screen_reg(bgtr_pkg::REG_WIDTH, 13'd640);
    set_screen_reg(bgtr_pkg::REG_HEIGHT, 13'd480);
    add_text(20);
    drain_text();

    if (errors == 0) begin
      $display("bitmap_glyph_text_rasterizer regression: pass");
    end else begin
      $display("bitmap_glyph_text_rasterizer regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bgtr_pkg.sv
hdl/bgtr_front.sv
hdl/bgtr_queue.sv
hdl/bgtr_back.sv
hdl/bitmap_glyph_text_rasterizer.sv
bench/bitmap_glyph_text_rasterizer_test.sv
